[rtl/core/vna_pkg.sv]
// vna_pkg: shared types, controller states and helpers for the vertex normal accumulator.
// Depends on nothing; used by vna_ctrl, vna_dp and the top level.
package vna_pkg;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
		logic [15:0]        cnt;
	} entry_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD_CHK,
		S_ADD_WR,
		S_Q_RD,
		S_Q_LEN,
		S_Q_CHK,
		S_C_INIT,
		S_C_DIV,
		S_C_SQRT,
		S_C_STORE,
		S_Q_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       clr;
		logic       add_rd;
		logic       add_wr;
		logic       q_rd;
		logic       sq;
		logic       div_init;
		logic       div_step;
		logic       sqrt_step;
		logic       store;
		logic       out_load;
		logic [1:0] sel;
		logic [3:0] bitsel;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic skip;
		logic qry_zero;
		logic out_free;
	} dp_sts_t;

	localparam int DIV_STEPS  = 31;
	localparam int SQRT_STEPS = 16;

	function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
		input logic signed [15:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {{17{b[15]}}, b};
		if (s[32] != s[31]) begin
			sat_add32 = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sat_add32 = s[31:0];
		end
	endfunction

endpackage

[rtl/core/vna_ctrl.sv]
// vna_ctrl: sequencing state machine for clear, face add and vertex query.
// Depends on vna_pkg; drives vna_dp through dp_cmd_t.
module vna_ctrl
	import vna_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    item_is_query,
	input  dp_sts_t sts,
	output dp_cmd_t cmd_o
);

	state_t     state_q, state_d;
	logic [1:0] sel_q, sel_d;
	logic [4:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sel_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:   if (sts.clear_last) state_d = S_IDLE;
			S_IDLE:    if (in_valid) state_d = item_is_query ? S_Q_RD : S_ADD_CHK;
			S_ADD_CHK: begin
				if (!sts.skip) state_d = S_ADD_WR;
				else if (sel_q == 2'd3) state_d = S_IDLE;
			end
			S_ADD_WR:  state_d = (sel_q == 2'd3) ? S_IDLE : S_ADD_CHK;
			S_Q_RD:    state_d = S_Q_LEN;
			S_Q_LEN:   if (sel_q == 2'd2) state_d = S_Q_CHK;
			S_Q_CHK:   state_d = sts.qry_zero ? S_Q_OUT : S_C_INIT;
			S_C_INIT:  state_d = S_C_DIV;
			S_C_DIV:   if (step_q == 5'(DIV_STEPS - 1)) state_d = S_C_SQRT;
			S_C_SQRT:  if (step_q == 5'(SQRT_STEPS - 1)) state_d = S_C_STORE;
			S_C_STORE: state_d = (sel_q == 2'd2) ? S_Q_OUT : S_C_INIT;
			S_Q_OUT:   if (sts.out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_o        = '0;
		cmd_o.sel    = sel_q;
		cmd_o.bitsel = 4'(SQRT_STEPS - 1) - step_q[3:0];
		in_stall     = 1'b1;
		sel_d        = sel_q;
		step_d       = step_q;
		unique case (state_q)
			S_CLEAR:   cmd_o.clr = 1'b1;
			S_IDLE: begin
				in_stall   = 1'b0;
				cmd_o.load = in_valid;
				sel_d      = '0;
			end
			S_ADD_CHK: begin
				cmd_o.add_rd = !sts.skip;
				if (sts.skip) sel_d = sel_q + 2'd1;
			end
			S_ADD_WR: begin
				cmd_o.add_wr = 1'b1;
				sel_d        = sel_q + 2'd1;
			end
			S_Q_RD: begin
				cmd_o.q_rd = 1'b1;
				sel_d      = '0;
			end
			S_Q_LEN: begin
				cmd_o.sq = 1'b1;
				sel_d    = (sel_q == 2'd2) ? 2'd0 : sel_q + 2'd1;
			end
			S_Q_CHK:   sel_d = '0;
			S_C_INIT: begin
				cmd_o.div_init = 1'b1;
				step_d         = '0;
			end
			S_C_DIV: begin
				cmd_o.div_step = 1'b1;
				step_d = (step_q == 5'(DIV_STEPS - 1)) ? 5'd0 : step_q + 5'd1;
			end
			S_C_SQRT: begin
				cmd_o.sqrt_step = 1'b1;
				step_d          = step_q + 5'd1;
			end
			S_C_STORE: begin
				cmd_o.store = 1'b1;
				sel_d       = sel_q + 2'd1;
			end
			S_Q_OUT:   cmd_o.out_load = sts.out_free;
			default:   cmd_o = '0;
		endcase
	end

endmodule

[rtl/core/vna_dp.sv]
// vna_dp: vertex store, saturating accumulate, length, divider, square root, output register.
// Depends on vna_pkg; commanded by vna_ctrl.
module vna_dp
	import vna_pkg::*;
#(
	parameter int VERTICES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd_i,
	output dp_sts_t            sts,
	input  logic               cmd,
	input  logic [11:0]        vertex_a,
	input  logic [11:0]        vertex_b,
	input  logic [11:0]        vertex_c,
	input  logic [11:0]        vertex_d,
	input  logic               is_quad,
	input  logic signed [15:0] face_nx,
	input  logic signed [15:0] face_ny,
	input  logic signed [15:0] face_nz,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] normal_out_x,
	output logic signed [15:0] normal_out_y,
	output logic signed [15:0] normal_out_z,
	output logic               has_faces
);

	localparam int AW = $clog2(VERTICES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(VERTICES - 1);

	logic               cmd_q;
	logic [11:0]        corner_q [4];
	logic               quad_q;
	logic signed [15:0] nx_q, ny_q, nz_q;

	entry_t        mem_q [VERTICES];
	entry_t        rd_q;
	logic [AW-1:0] clr_addr_q;

	logic [63:0]        len2_q;
	logic [63:0]        rem_q;
	logic [30:0]        nlow_q;
	logic [30:0]        quo_q;
	logic [15:0]        root_q;
	logic signed [15:0] res_q [3];

	logic               out_valid_q;
	logic signed [15:0] ox_q, oy_q, oz_q;
	logic               has_q;

	logic [11:0]        cur_corner;
	logic               dup, c_inrange, q_inrange;
	logic [AW-1:0]      waddr, raddr;
	logic               we, re;
	entry_t             wdata, upd;
	logic signed [31:0] comp;
	logic [31:0]        mag;
	logic [63:0]        prod;
	logic [64:0]        r2;
	logic               ge;
	logic [15:0]        trial;
	logic [31:0]        trial_sq;
	logic signed [15:0] res_val;

	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			cmd_q       <= cmd;
			corner_q[0] <= vertex_a;
			corner_q[1] <= vertex_b;
			corner_q[2] <= vertex_c;
			corner_q[3] <= vertex_d;
			quad_q      <= is_quad;
			nx_q        <= face_nx;
			ny_q        <= face_ny;
			nz_q        <= face_nz;
		end
	end

	assign cur_corner = corner_q[cmd_i.sel];
	assign c_inrange  = {20'd0, cur_corner} < 32'(VERTICES);
	assign q_inrange  = {20'd0, corner_q[0]} < 32'(VERTICES);

	always_comb begin
		dup = 1'b0;
		for (int j = 0; j < 3; j++) begin
			if (2'(j) < cmd_i.sel && corner_q[j] == cur_corner) dup = 1'b1;
		end
	end

	assign sts.skip       = dup || !c_inrange || (cmd_i.sel == 2'd3 && !quad_q);
	assign sts.clear_last = (clr_addr_q == LAST_ADDR);
	assign sts.qry_zero   = !q_inrange || (len2_q == 64'd0);
	assign sts.out_free   = !out_valid_q || !out_stall;

	always_comb begin
		upd.sx  = sat_add32(rd_q.sx, nx_q);
		upd.sy  = sat_add32(rd_q.sy, ny_q);
		upd.sz  = sat_add32(rd_q.sz, nz_q);
		upd.cnt = (rd_q.cnt == 16'hffff) ? rd_q.cnt : rd_q.cnt + 16'd1;
	end

	assign we    = cmd_i.clr || cmd_i.add_wr;
	assign waddr = cmd_i.clr ? clr_addr_q : AW'(cur_corner);
	assign wdata = cmd_i.clr ? entry_t'('0) : upd;
	assign re    = cmd_i.add_rd || cmd_i.q_rd;
	assign raddr = cmd_i.q_rd ? AW'(corner_q[0]) : AW'(cur_corner);

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rd_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd_i.clr && !sts.clear_last) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_comb begin
		unique case (cmd_i.sel)
			2'd0:    comp = rd_q.sx;
			2'd1:    comp = rd_q.sy;
			default: comp = rd_q.sz;
		endcase
	end

	assign mag      = comp[31] ? (~comp + 32'd1) : comp;
	assign prod     = 64'(mag) * 64'(mag);
	assign r2       = {rem_q, nlow_q[30]};
	assign ge       = r2 >= {1'b0, len2_q};
	assign trial    = root_q | (16'd1 << cmd_i.bitsel);
	assign trial_sq = 32'(trial) * 32'(trial);

	always_comb begin
		if (comp[31]) begin
			res_val = -$signed(root_q);
		end else if (root_q[15]) begin
			res_val = 16'sh7fff;
		end else begin
			res_val = $signed(root_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.sq) len2_q <= ((cmd_i.sel == 2'd0) ? 64'd0 : len2_q) + prod;
		if (cmd_i.div_init) begin
			rem_q  <= {1'b0, prod[63:1]};
			nlow_q <= {prod[0], 30'd0};
			quo_q  <= '0;
			root_q <= '0;
		end
		if (cmd_i.div_step) begin
			rem_q  <= ge ? 64'(r2 - {1'b0, len2_q}) : r2[63:0];
			nlow_q <= {nlow_q[29:0], 1'b0};
			quo_q  <= {quo_q[29:0], ge};
		end
		if (cmd_i.sqrt_step && trial_sq <= {1'b0, quo_q}) root_q <= trial;
		if (cmd_i.store) res_q[cmd_i.sel] <= res_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.out_load) begin
			ox_q  <= sts.qry_zero ? 16'sd0 : res_q[0];
			oy_q  <= sts.qry_zero ? 16'sd0 : res_q[1];
			oz_q  <= sts.qry_zero ? 16'sd0 : res_q[2];
			has_q <= q_inrange && (rd_q.cnt != 16'd0) && cmd_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign normal_out_x = ox_q;
	assign normal_out_y = oy_q;
	assign normal_out_z = oz_q;
	assign has_faces    = has_q;

endmodule

[rtl/core/vertex_normal_accumulator_core.sv]
// Vertex normal accumulator top level: controller plus datapath.
// Add: each distinct in-range corner is read and then written back; other corners are skipped.
// Query: the shared 31-step divider and 16-step square root run once per axis in turn.
// Reset: asynchronous; then a clearing pass over all VERTICES entries stalls the input.
// A finished result waits in the output register while the next transaction is accepted.
module vertex_normal_accumulator_core
	import vna_pkg::*;
#(
	parameter int VERTICES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [11:0]        vertex_a,
	input  logic [11:0]        vertex_b,
	input  logic [11:0]        vertex_c,
	input  logic [11:0]        vertex_d,
	input  logic               is_quad,
	input  logic signed [15:0] face_nx,
	input  logic signed [15:0] face_ny,
	input  logic signed [15:0] face_nz,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] normal_out_x,
	output logic signed [15:0] normal_out_y,
	output logic signed [15:0] normal_out_z,
	output logic               has_faces
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	vna_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.item_is_query (cmd),
		.sts           (dp_sts),
		.cmd_o         (dp_cmd)
	);

	vna_dp #(.VERTICES(VERTICES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_i        (dp_cmd),
		.sts          (dp_sts),
		.cmd          (cmd),
		.vertex_a     (vertex_a),
		.vertex_b     (vertex_b),
		.vertex_c     (vertex_c),
		.vertex_d     (vertex_d),
		.is_quad      (is_quad),
		.face_nx      (face_nx),
		.face_ny      (face_ny),
		.face_nz      (face_nz),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.normal_out_x (normal_out_x),
		.normal_out_y (normal_out_y),
		.normal_out_z (normal_out_z),
		.has_faces    (has_faces)
	);

endmodule

[rtl/core/vna_checker.sv]
// vna_checker: port-level assertions for vertex_normal_accumulator_core.
// Depends on nothing; attached by the bind at the end of this file.
module vna_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] normal_out_x,
	input logic signed [15:0] normal_out_y,
	input logic signed [15:0] normal_out_z,
	input logic               has_faces
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(normal_out_x) && $stable(has_faces))
		else $error("stalled result changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction accepted while busy");

	a_untouched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_faces |-> normal_out_x == 16'sd0 && normal_out_y == 16'sd0
			&& normal_out_z == 16'sd0)
		else $error("nonzero normal for untouched vertex");

endmodule

bind vertex_normal_accumulator_core vna_checker u_vna_checker (.*);
